// ===== src/bdt_pkg.sv =====
package bdt_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int DEPTH_BITS    = 16;
  localparam int STEP_W        = 6;

  typedef struct packed {
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic signed [11:0] a_x;
    logic signed [11:0] a_y;
    logic [23:0]        a_w;
    logic signed [11:0] b_x;
    logic signed [11:0] b_y;
    logic [23:0]        b_w;
    logic signed [11:0] c_x;
    logic signed [11:0] c_y;
    logic [23:0]        c_w;
    logic [31:0]        fill_color;
  } in_t;

  typedef struct packed {
    logic        drawn;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [31:0] pixel_color;
    logic [15:0] depth_value;
    logic        gray_valid;
    logic [23:0] gray_color;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CROSS,
    ST_PREP,
    ST_RSTART,
    ST_RECIP,
    ST_MAC,
    ST_NUM,
    ST_DSTART,
    ST_DIV,
    ST_TEST,
    ST_OUT
  } state_t;

endpackage

// ===== src/bdt_in_if.sv =====
interface bdt_in_if;
  logic         valid;
  logic         ready;
  bdt_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/bdt_out_if.sv =====
interface bdt_out_if;
  logic          valid;
  logic          ready;
  bdt_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/barycentric_depth_test_fragment_unit.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    bdt_pkg::in_t  (fragment, vertices, w, color)
// out_ch   out  valid/ready    bdt_pkg::out_t (draw result, depth, gray)
// cfg      in   cfg_wr_en      cfg_wr_data    (depth view mode)
// Per fragment: six cross products on one multiplier, three reciprocals on one
// shift-subtract divider, six MAC products on the multiplier, then one depth quotient
// on the divider; zero area skips to the test, a negative numerator skips the quotient.
// After reset a clearing pass writes far depth to all SCREEN_WIDTH*SCREEN_HEIGHT
// entries, one per cycle, with in_ch.ready low.
// A stalled out_ch holds the finished transaction; the next fragment is taken
// once its result moves into the output register.
module barycentric_depth_test_fragment_unit #(
  parameter int SCREEN_WIDTH  = bdt_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = bdt_pkg::SCREEN_HEIGHT,
  parameter int DEPTH_BITS    = bdt_pkg::DEPTH_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  bdt_in_if.sink    in_ch,
  bdt_out_if.source out_ch
);

  localparam int D     = DEPTH_BITS;
  localparam int RW    = D + 13;
  localparam int RLO   = (RW + 1) / 2;
  localparam int CW    = 28;
  localparam int MBW   = (RLO + 1 > 13) ? RLO + 1 : 13;
  localparam int PW    = CW + MBW;
  localparam int ACC_W = D + 46;
  localparam int NPIX  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(NPIX);
  localparam int XB    = $clog2(SCREEN_WIDTH);
  localparam int YB    = $clog2(SCREEN_HEIGHT);
  localparam logic [D-1:0] DMAX = {D{1'b1}};

  bdt_pkg::state_t    state_r, state_nxt;
  bdt_pkg::in_t       item_r;
  bdt_pkg::out_t      res_r, out_r;
  bdt_pkg::div_cmd_t  div_cmd;
  bdt_pkg::div_stat_t div_stat;

  logic [2:0]               cnt_r;
  logic [1:0]               rsel_r;
  logic signed [CW-1:0]     area_r, ca_r, cb_r, cc_r, area_abs;
  logic signed [PW-1:0]     prod_r, mul;
  logic signed [CW-1:0]     ma;
  logic signed [MBW-1:0]    mb;
  logic [RW-1:0]            rcp_r [3];
  logic signed [ACC_W-1:0]  acc_r, num_r, pext;
  logic [D-1:0]             depth_r, rd_r;
  logic                     zero_r, out_valid_r, view_r;
  logic [AW-1:0]            clr_r, addr;
  logic [D-1:0]             mem [NPIX];
  logic [ACC_W-1:0]         div_dvd, div_dsr;
  logic [RW-1:0]            div_q;
  logic [23:0]              wsel;
  logic [RW-1:0]            rpick;
  logic signed [CW-1:0]     coef;
  logic signed [12:0]       dxca, dyca, dxba, dyba, dxcp, dycp, dxbp, dybp, dxpa, dypa;
  logic                     onscr, drawn, in_acc;
  logic [D+7:0]             gtmp;
  logic [D+15:0]            dtmp;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == bdt_pkg::ST_IDLE);

  assign dxca = 13'(item_r.c_x) - 13'(item_r.a_x);
  assign dyca = 13'(item_r.c_y) - 13'(item_r.a_y);
  assign dxba = 13'(item_r.b_x) - 13'(item_r.a_x);
  assign dyba = 13'(item_r.b_y) - 13'(item_r.a_y);
  assign dxcp = 13'(item_r.c_x) - 13'(item_r.pixel_x);
  assign dycp = 13'(item_r.c_y) - 13'(item_r.pixel_y);
  assign dxbp = 13'(item_r.b_x) - 13'(item_r.pixel_x);
  assign dybp = 13'(item_r.b_y) - 13'(item_r.pixel_y);
  assign dxpa = 13'(item_r.pixel_x) - 13'(item_r.a_x);
  assign dypa = 13'(item_r.pixel_y) - 13'(item_r.a_y);

  always_comb begin
    case (cnt_r[2:1])
      2'd0: begin coef = ca_r; rpick = rcp_r[0]; end
      2'd1: begin coef = cb_r; rpick = rcp_r[1]; end
      default: begin coef = cc_r; rpick = rcp_r[2]; end
    endcase
    ma = '0;
    mb = '0;
    if (state_r == bdt_pkg::ST_CROSS) begin
      case (cnt_r)
        3'd0: begin ma = CW'(dxca); mb = MBW'(dyba); end
        3'd1: begin ma = CW'(dyca); mb = MBW'(dxba); end
        3'd2: begin ma = CW'(dxcp); mb = MBW'(dybp); end
        3'd3: begin ma = CW'(dycp); mb = MBW'(dxbp); end
        3'd4: begin ma = CW'(dxca); mb = MBW'(dypa); end
        3'd5: begin ma = CW'(dyca); mb = MBW'(dxpa); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else begin
      ma = coef;
      if (cnt_r[0]) begin
        mb = signed'(MBW'(rpick[RW-1:RLO]));
      end else begin
        mb = signed'(MBW'(rpick[RLO-1:0]));
      end
    end
  end

  assign mul  = ma * mb;
  assign pext = ACC_W'(prod_r);
  assign area_abs = area_r[CW-1] ? -area_r : area_r;

  always_comb begin
    case (rsel_r)
      2'd0: wsel = item_r.a_w;
      2'd1: wsel = item_r.b_w;
      default: wsel = item_r.c_w;
    endcase
    if (wsel == '0) begin
      wsel = 24'd1;
    end
  end

  always_comb begin
    if (state_r == bdt_pkg::ST_RSTART) begin
      div_dvd = ACC_W'(1) << (12 + D);
      div_dsr = ACC_W'(wsel) << (12 + D);
    end else begin
      div_dvd = ACC_W'(num_r);
      div_dsr = ACC_W'(area_abs) << D;
    end
  end

  bdt_div #(.W(ACC_W), .QW(RW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (div_cmd),
    .dividend   (div_dvd),
    .divisor_sh (div_dsr),
    .stat       (div_stat),
    .quotient   (div_q)
  );

  assign onscr = !item_r.pixel_x[11] && !item_r.pixel_y[11]
              && ({1'b0, item_r.pixel_x} < 13'(SCREEN_WIDTH))
              && ({1'b0, item_r.pixel_y} < 13'(SCREEN_HEIGHT));
  assign addr  = AW'(AW'(item_r.pixel_y[YB-1:0]) * AW'(SCREEN_WIDTH))
               + AW'(item_r.pixel_x[XB-1:0]);
  assign drawn = !zero_r && onscr && (depth_r < rd_r);
  assign gtmp  = {depth_r, 8'd0} - (D+8)'(depth_r);
  assign dtmp  = {depth_r, 16'd0} >> D;

  always_comb begin
    state_nxt     = state_r;
    div_cmd.start = 1'b0;
    div_cmd.steps = bdt_pkg::STEP_W'(RW);
    case (state_r)
      bdt_pkg::ST_CLEAR: if (clr_r == AW'(NPIX - 1)) state_nxt = bdt_pkg::ST_IDLE;
      bdt_pkg::ST_IDLE: if (in_acc) state_nxt = bdt_pkg::ST_CROSS;
      bdt_pkg::ST_CROSS: if (cnt_r == 3'd6) state_nxt = bdt_pkg::ST_PREP;
      bdt_pkg::ST_PREP: begin
        state_nxt = (area_r == '0) ? bdt_pkg::ST_TEST : bdt_pkg::ST_RSTART;
      end
      bdt_pkg::ST_RSTART: begin
        div_cmd.start = 1'b1;
        state_nxt     = bdt_pkg::ST_RECIP;
      end
      bdt_pkg::ST_RECIP: begin
        if (!div_stat.busy) begin
          state_nxt = (rsel_r == 2'd2) ? bdt_pkg::ST_MAC : bdt_pkg::ST_RSTART;
        end
      end
      bdt_pkg::ST_MAC: if (cnt_r == 3'd6) state_nxt = bdt_pkg::ST_NUM;
      bdt_pkg::ST_NUM: state_nxt = bdt_pkg::ST_DSTART;
      bdt_pkg::ST_DSTART: begin
        if (num_r[ACC_W-1]) begin
          state_nxt = bdt_pkg::ST_TEST;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.steps = bdt_pkg::STEP_W'(D + 1);
          state_nxt     = bdt_pkg::ST_DIV;
        end
      end
      bdt_pkg::ST_DIV: if (!div_stat.busy) state_nxt = bdt_pkg::ST_TEST;
      bdt_pkg::ST_TEST: state_nxt = bdt_pkg::ST_OUT;
      bdt_pkg::ST_OUT: if (!out_valid_r || out_ch.ready) state_nxt = bdt_pkg::ST_IDLE;
      default: state_nxt = bdt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdt_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      view_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bdt_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_wr_en) begin
        view_r <= cfg_wr_data;
      end
      if (state_r == bdt_pkg::ST_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bdt_pkg::ST_IDLE: begin
        item_r <= in_ch.data;
        cnt_r  <= '0;
        rsel_r <= '0;
      end
      bdt_pkg::ST_CROSS: begin
        prod_r <= mul;
        cnt_r  <= cnt_r + 1'b1;
        case (cnt_r)
          3'd1: area_r <= CW'(prod_r);
          3'd2: area_r <= area_r - CW'(prod_r);
          3'd3: ca_r   <= CW'(prod_r);
          3'd4: ca_r   <= ca_r - CW'(prod_r);
          3'd5: cb_r   <= CW'(prod_r);
          3'd6: cb_r   <= cb_r - CW'(prod_r);
          default: ;
        endcase
      end
      bdt_pkg::ST_PREP: begin
        cc_r    <= area_r - ca_r - cb_r;
        zero_r  <= (area_r == '0);
        depth_r <= '0;
      end
      bdt_pkg::ST_RECIP: begin
        if (!div_stat.busy) begin
          rcp_r[rsel_r] <= div_q;
          rsel_r        <= rsel_r + 1'b1;
          cnt_r         <= '0;
          acc_r         <= '0;
        end
      end
      bdt_pkg::ST_MAC: begin
        prod_r <= mul;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r != 3'd0) begin
          if (cnt_r[0]) begin
            acc_r <= acc_r + pext;
          end else begin
            acc_r <= acc_r + (pext <<< RLO);
          end
        end
      end
      bdt_pkg::ST_NUM: begin
        num_r <= (area_r[CW-1] ? acc_r : -acc_r) + (ACC_W'(area_abs) <<< D);
      end
      bdt_pkg::ST_DSTART: depth_r <= '0;
      bdt_pkg::ST_DIV: begin
        if (!div_stat.busy) begin
          depth_r <= div_q[D] ? DMAX : div_q[D-1:0];
        end
      end
      bdt_pkg::ST_TEST: begin
        res_r.drawn       <= drawn;
        res_r.out_x       <= drawn ? item_r.pixel_x[7:0] : 8'd0;
        res_r.out_y       <= drawn ? item_r.pixel_y[7:0] : 8'd0;
        res_r.pixel_color <= drawn ? item_r.fill_color : 32'd0;
        res_r.depth_value <= dtmp[15:0];
        res_r.gray_valid  <= drawn && view_r;
        res_r.gray_color  <= (drawn && view_r) ? {3{gtmp[D+7:D]}} : 24'd0;
      end
      bdt_pkg::ST_OUT: if (!out_valid_r || out_ch.ready) out_r <= res_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[addr];
    if (state_r == bdt_pkg::ST_CLEAR) begin
      mem[clr_r] <= DMAX;
    end else if (state_r == bdt_pkg::ST_TEST && drawn) begin
      mem[addr] <= depth_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdt_pkg::ST_CLEAR |-> !in_ch.ready) else $error("ready during clear");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("ready after accept");
  a_gray_needs_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.drawn |-> !out_ch.data.gray_valid)
    else $error("gray without draw");
  a_div_idle_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdt_pkg::ST_IDLE |-> !div_stat.busy) else $error("divider busy when idle");
`endif

endmodule

// ===== src/bdt_div.sv =====
module bdt_div #(
  parameter int W  = 64,
  parameter int QW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bdt_pkg::div_cmd_t   cmd,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor_sh,
  output bdt_pkg::div_stat_t  stat,
  output logic [QW-1:0]       quotient
);

  logic [W-1:0]               rem_r;
  logic [W-1:0]               dsr_r;
  logic [QW-1:0]              q_r;
  logic [bdt_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       ge;

  assign ge = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == bdt_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= dividend;
      dsr_r <= divisor_sh;
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      q_r   <= {q_r[QW-2:0], ge};
      dsr_r <= dsr_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign quotient  = q_r;

endmodule
